// ===== design/snfcs_pkg.sv =====
// shared types, command codes and flash opcode bytes for the spi nor command sequencer
package snfcs_pkg;

  localparam int PAGE_BYTES_DEF   = 256;
  localparam int ADDRESS_BITS_DEF = 24;

  localparam int MAX_RES = 6;
  localparam int CNT_W   = 3;

  typedef enum logic [2:0] {
    OP_READ_ID     = 3'd0,
    OP_POWER_DOWN  = 3'd1,
    OP_RELEASE     = 3'd2,
    OP_ERASE       = 3'd3,
    OP_PROG_START  = 3'd4,
    OP_PROG_BYTE   = 3'd5,
    OP_READ_START  = 3'd6,
    OP_REPLY       = 3'd7
  } op_t;

  localparam logic [7:0] CMD_WREN    = 8'h06;
  localparam logic [7:0] CMD_PROGRAM = 8'h02;
  localparam logic [7:0] CMD_ERASE   = 8'h20;
  localparam logic [7:0] CMD_STATUS  = 8'h05;
  localparam logic [7:0] CMD_JEDEC   = 8'h9F;
  localparam logic [7:0] CMD_PWRDN   = 8'hB9;
  localparam logic [7:0] CMD_WAKE    = 8'hAB;
  localparam logic [7:0] CMD_READ    = 8'h03;
  localparam logic [7:0] DUMMY_BYTE  = 8'hFF;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       reply_wanted;
    logic       release_cs;
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic       done_res;
    logic       error;
    logic       last;
  } res_t;

  typedef res_t [MAX_RES-1:0] burst_t;

  function automatic res_t mk_res(input logic txv, input logic [7:0] tx, input logic rep,
                                  input logic rel, input logic rxv, input logic [7:0] rx,
                                  input logic done);
    res_t r;
    r.tx_valid     = txv;
    r.tx_byte      = txv ? tx : 8'h00;
    r.reply_wanted = rep;
    r.release_cs   = rel;
    r.rx_valid     = rxv;
    r.rx_byte      = rxv ? rx : 8'h00;
    r.done_res     = done;
    r.error        = 1'b0;
    r.last         = 1'b0;
    return r;
  endfunction

endpackage

// ===== design/snfcs_core.sv =====
// command decode and sequencer state: turns one held command into a burst of results
module snfcs_core import snfcs_pkg::*; #(
  parameter int PAGE_BYTES   = PAGE_BYTES_DEF,
  parameter int ADDRESS_BITS = ADDRESS_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             go_i,
  input  op_t              op_i,
  input  logic [23:0]      addr_i,
  input  logic [23:0]      len_i,
  input  logic [7:0]       byte_i,
  output burst_t           burst_o,
  output logic [CNT_W-1:0] count_o
);

  localparam int FA_W = (ADDRESS_BITS < 24) ? ADDRESS_BITS : 24;
  localparam int PO_W = $clog2(PAGE_BYTES);
  localparam int PG_W = PO_W + 1;
  localparam logic [PG_W-1:0] PAGE_SPAN = PG_W'(PAGE_BYTES);

  typedef enum logic [2:0] {
    PH_IDLE, PH_ID, PH_PROG, PH_READ, PH_POLL_CMD, PH_POLL_STAT
  } phase_t;

  localparam logic [1:0] AP_NONE  = 2'd0;
  localparam logic [1:0] AP_ERASE = 2'd1;
  localparam logic [1:0] AP_PROG  = 2'd2;

  phase_t          phase_r, phase_nxt;
  logic [FA_W-1:0] fa_r, fa_nxt;
  logic [23:0]     bl_r, bl_nxt;
  logic [PG_W-1:0] pl_r, pl_nxt;
  logic [1:0]      ap_r, ap_nxt;
  logic [1:0]      id_r, id_nxt;

  logic [FA_W-1:0] addr_m;
  logic [FA_W-1:0] chunk_fa;
  logic [23:0]     chunk_bl;
  logic [23:0]     chunk_a;
  logic [23:0]     addr_b;
  logic [PG_W-1:0] space;
  logic [PG_W-1:0] chunk_pl;
  logic [23:0]     bl_dec;
  logic [PG_W-1:0] pl_dec;
  logic [1:0]      id_dec;
  burst_t          ent;
  logic [CNT_W-1:0] n;
  logic             err;

  assign addr_m   = addr_i[FA_W-1:0];
  assign addr_b   = 24'(addr_m);
  // a fresh program starts from the command fields, a later chunk from the running state
  assign chunk_fa = (phase_r == PH_IDLE) ? addr_m : fa_r;
  assign chunk_bl = (phase_r == PH_IDLE) ? len_i : bl_r;
  assign chunk_a  = 24'(chunk_fa);
  assign space    = PAGE_SPAN - {1'b0, chunk_fa[PO_W-1:0]};
  assign chunk_pl = (chunk_bl < 24'(space)) ? chunk_bl[PG_W-1:0] : space;
  assign bl_dec   = bl_r - 24'd1;
  assign pl_dec   = pl_r - PG_W'(1);
  assign id_dec   = id_r - 2'd1;

  always_comb begin
    phase_nxt = phase_r;
    fa_nxt    = fa_r;
    bl_nxt    = bl_r;
    pl_nxt    = pl_r;
    ap_nxt    = ap_r;
    id_nxt    = id_r;
    ent       = '0;
    n         = CNT_W'(1);
    err       = 1'b0;
    unique case (phase_r)
      PH_IDLE: begin
        unique case (op_i)
          OP_READ_ID: begin
            ent[0] = mk_res(1'b1, CMD_JEDEC, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0);
            ent[1] = mk_res(1'b1, DUMMY_BYTE, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0);
            ent[2] = mk_res(1'b1, DUMMY_BYTE, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0);
            ent[3] = mk_res(1'b1, DUMMY_BYTE, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0);
            n         = CNT_W'(4);
            id_nxt    = 2'd3;
            phase_nxt = PH_ID;
          end
          OP_POWER_DOWN: begin
            ent[0] = mk_res(1'b1, CMD_PWRDN, 1'b0, 1'b1, 1'b0, 8'h00, 1'b1);
          end
          OP_RELEASE: begin
            ent[0] = mk_res(1'b1, CMD_WAKE, 1'b0, 1'b1, 1'b0, 8'h00, 1'b1);
          end
          OP_ERASE: begin
            ent[0] = mk_res(1'b1, CMD_WREN, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0);
            ent[1] = mk_res(1'b1, CMD_ERASE, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0);
            ent[2] = mk_res(1'b1, addr_b[23:16], 1'b0, 1'b0, 1'b0, 8'h00, 1'b0);
            ent[3] = mk_res(1'b1, addr_b[15:8], 1'b0, 1'b0, 1'b0, 8'h00, 1'b0);
            ent[4] = mk_res(1'b1, addr_b[7:0], 1'b0, 1'b1, 1'b0, 8'h00, 1'b0);
            ent[5] = mk_res(1'b1, CMD_STATUS, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0);
            n         = CNT_W'(6);
            fa_nxt    = addr_m;
            ap_nxt    = AP_ERASE;
            phase_nxt = PH_POLL_CMD;
          end
          OP_PROG_START: begin
            if (len_i == 24'd0) begin
              ent[0] = mk_res(1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 8'h00, 1'b1);
            end else begin
              ent[0] = mk_res(1'b1, CMD_WREN, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0);
              ent[1] = mk_res(1'b1, CMD_PROGRAM, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0);
              ent[2] = mk_res(1'b1, chunk_a[23:16], 1'b0, 1'b0, 1'b0, 8'h00, 1'b0);
              ent[3] = mk_res(1'b1, chunk_a[15:8], 1'b0, 1'b0, 1'b0, 8'h00, 1'b0);
              ent[4] = mk_res(1'b1, chunk_a[7:0], 1'b0, 1'b0, 1'b0, 8'h00, 1'b0);
              n         = CNT_W'(5);
              fa_nxt    = addr_m;
              bl_nxt    = len_i;
              pl_nxt    = chunk_pl;
              phase_nxt = PH_PROG;
            end
          end
          OP_READ_START: begin
            ent[0] = mk_res(1'b1, CMD_READ, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0);
            ent[1] = mk_res(1'b1, addr_b[23:16], 1'b0, 1'b0, 1'b0, 8'h00, 1'b0);
            ent[2] = mk_res(1'b1, addr_b[15:8], 1'b0, 1'b0, 1'b0, 8'h00, 1'b0);
            fa_nxt = addr_m;
            if (len_i == 24'd0) begin
              ent[3] = mk_res(1'b1, addr_b[7:0], 1'b0, 1'b1, 1'b0, 8'h00, 1'b1);
              n      = CNT_W'(4);
            end else begin
              ent[3] = mk_res(1'b1, addr_b[7:0], 1'b0, 1'b0, 1'b0, 8'h00, 1'b0);
              ent[4] = mk_res(1'b1, DUMMY_BYTE, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0);
              n         = CNT_W'(5);
              bl_nxt    = len_i;
              phase_nxt = PH_READ;
            end
          end
          default: err = 1'b1;
        endcase
      end
      PH_ID: begin
        if (op_i == OP_REPLY) begin
          id_nxt = id_dec;
          ent[0] = mk_res(1'b0, 8'h00, 1'b0, 1'b0, 1'b1, byte_i, id_dec == 2'd0);
          if (id_dec == 2'd0) phase_nxt = PH_IDLE;
        end else begin
          err = 1'b1;
        end
      end
      PH_READ: begin
        if (op_i == OP_REPLY) begin
          bl_nxt = bl_dec;
          fa_nxt = fa_r + FA_W'(1);
          if (bl_dec == 24'd0) begin
            ent[0]    = mk_res(1'b0, 8'h00, 1'b0, 1'b1, 1'b1, byte_i, 1'b1);
            phase_nxt = PH_IDLE;
          end else begin
            ent[0] = mk_res(1'b0, 8'h00, 1'b0, 1'b0, 1'b1, byte_i, 1'b0);
            ent[1] = mk_res(1'b1, DUMMY_BYTE, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0);
            n      = CNT_W'(2);
          end
        end else begin
          err = 1'b1;
        end
      end
      PH_PROG: begin
        if (op_i == OP_PROG_BYTE) begin
          fa_nxt = fa_r + FA_W'(1);
          bl_nxt = bl_dec;
          pl_nxt = pl_dec;
          if (pl_dec == '0) begin
            ent[0]    = mk_res(1'b1, byte_i, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0);
            ent[1]    = mk_res(1'b1, CMD_STATUS, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0);
            n         = CNT_W'(2);
            ap_nxt    = AP_PROG;
            phase_nxt = PH_POLL_CMD;
          end else begin
            ent[0] = mk_res(1'b1, byte_i, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0);
          end
        end else begin
          err = 1'b1;
        end
      end
      PH_POLL_CMD: begin
        // the byte clocked in during the status opcode is a dummy
        if (op_i == OP_REPLY) begin
          ent[0]    = mk_res(1'b1, DUMMY_BYTE, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0);
          phase_nxt = PH_POLL_STAT;
        end else begin
          err = 1'b1;
        end
      end
      PH_POLL_STAT: begin
        if (op_i != OP_REPLY) begin
          err = 1'b1;
        end else if (byte_i[0]) begin
          ent[0] = mk_res(1'b1, DUMMY_BYTE, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0);
        end else if (ap_r == AP_PROG && bl_r != 24'd0) begin
          // busy cleared mid program: next page chunk
          ent[0] = mk_res(1'b0, 8'h00, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0);
          ent[1] = mk_res(1'b1, CMD_WREN, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0);
          ent[2] = mk_res(1'b1, CMD_PROGRAM, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0);
          ent[3] = mk_res(1'b1, chunk_a[23:16], 1'b0, 1'b0, 1'b0, 8'h00, 1'b0);
          ent[4] = mk_res(1'b1, chunk_a[15:8], 1'b0, 1'b0, 1'b0, 8'h00, 1'b0);
          ent[5] = mk_res(1'b1, chunk_a[7:0], 1'b0, 1'b0, 1'b0, 8'h00, 1'b0);
          n         = CNT_W'(6);
          pl_nxt    = chunk_pl;
          phase_nxt = PH_PROG;
        end else begin
          ent[0]    = mk_res(1'b0, 8'h00, 1'b0, 1'b1, 1'b0, 8'h00, 1'b1);
          ap_nxt    = AP_NONE;
          phase_nxt = PH_IDLE;
        end
      end
      default: err = 1'b1;
    endcase
    if (err) begin
      ent          = '0;
      ent[0].error = 1'b1;
      n            = CNT_W'(1);
      phase_nxt    = phase_r;
      fa_nxt       = fa_r;
      bl_nxt       = bl_r;
      pl_nxt       = pl_r;
      ap_nxt       = ap_r;
      id_nxt       = id_r;
    end
    for (int i = 0; i < MAX_RES; i++) begin
      ent[i].last = (CNT_W'(i) == n - CNT_W'(1));
    end
  end

  assign burst_o = ent;
  assign count_o = n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      fa_r    <= '0;
      bl_r    <= '0;
      pl_r    <= '0;
      ap_r    <= AP_NONE;
      id_r    <= '0;
    end else if (go_i) begin
      phase_r <= phase_nxt;
      fa_r    <= fa_nxt;
      bl_r    <= bl_nxt;
      pl_r    <= pl_nxt;
      ap_r    <= ap_nxt;
      id_r    <= id_nxt;
    end
  end

  a_id_pending: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_ID |-> id_r != 2'd0)
    else $error("id phase with no id bytes pending");

  a_read_pending: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_READ |-> bl_r != 24'd0)
    else $error("read phase with no bytes left");

  a_page_pending: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_PROG |-> (pl_r != '0 && {{(24-PG_W){1'b0}}, pl_r} <= bl_r))
    else $error("program chunk count out of range");

  a_poll_owner: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_POLL_CMD || phase_r == PH_POLL_STAT) |-> ap_r != AP_NONE)
    else $error("busy poll without a pending command");

endmodule

// ===== design/snfcs_emit.sv =====
// result buffer: holds one burst, emits one transaction per ready cycle
module snfcs_emit import snfcs_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load_i,
  input  burst_t           burst_i,
  input  logic [CNT_W-1:0] count_i,
  output logic             can_load_o,
  output logic             out_valid,
  input  logic             out_ready,
  output res_t             res_o
);

  burst_t           ent_r;
  logic [CNT_W-1:0] cnt_r;
  logic             take;

  assign out_valid  = (cnt_r != '0);
  assign take       = out_valid && out_ready;
  // free now, or the final entry leaves this cycle
  assign can_load_o = (cnt_r == '0) || (take && cnt_r == CNT_W'(1));
  assign res_o      = ent_r[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (load_i) begin
      cnt_r <= count_i;
    end else if (take) begin
      cnt_r <= cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load_i) begin
      ent_r <= burst_i;
    end else if (take) begin
      for (int i = 0; i < MAX_RES - 1; i++) begin
        ent_r[i] <= ent_r[i+1];
      end
      ent_r[MAX_RES-1] <= '0;
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_RES))
    else $error("result count beyond burst depth");

  a_last_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (res_o.last == (cnt_r == CNT_W'(1))))
    else $error("last flag not on the final result of a burst");

  a_error_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && res_o.error |-> (!res_o.tx_valid && !res_o.rx_valid && res_o.last))
    else $error("error result carries data");

endmodule

// ===== design/spi_nor_flash_command_sequencer.sv =====
// top level of the spi nor flash command sequencer
//
//  channel | signals                                         | direction
//  --------+-------------------------------------------------+----------
//  in_     | valid/ready, opcode, address, length, byte_value | to block
//  out_    | valid/ready, tx_valid .. last (one result each)  | from block
//
// a command is held in the input register until the result buffer can take it, decoded
// combinationally into a burst of 1 to 6 results, and the burst leaves at one transaction
// per cycle while out_ready is high; the input register takes the next command meanwhile
// the next command is decoded in the cycle the last result of a burst is taken
// a stall on out_ready holds the buffer and, once the input register is full, in_ready
// synchronous active-low reset returns the sequencer to idle with nothing buffered
// PAGE_BYTES must be a power of two
module spi_nor_flash_command_sequencer import snfcs_pkg::*; #(
  parameter int PAGE_BYTES   = PAGE_BYTES_DEF,
  parameter int ADDRESS_BITS = ADDRESS_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_opcode,
  input  logic [23:0] in_address,
  input  logic [23:0] in_length,
  input  logic [7:0]  in_byte_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_tx_valid,
  output logic [7:0]  out_tx_byte,
  output logic        out_reply_wanted,
  output logic        out_release_cs,
  output logic        out_rx_valid,
  output logic [7:0]  out_rx_byte,
  output logic        out_done_res,
  output logic        out_error,
  output logic        out_last
);

  logic             hold_v_r;
  op_t              op_r;
  logic [23:0]      addr_r;
  logic [23:0]      len_r;
  logic [7:0]       byte_r;
  logic             can_load;
  logic             load;
  burst_t           burst;
  logic [CNT_W-1:0] count;
  res_t             res;

  assign load     = hold_v_r && can_load;
  assign in_ready = !hold_v_r || load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      hold_v_r <= 1'b1;
    end else if (load) begin
      hold_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_r   <= op_t'(in_opcode);
      addr_r <= in_address;
      len_r  <= in_length;
      byte_r <= in_byte_value;
    end
  end

  snfcs_core #(
    .PAGE_BYTES   (PAGE_BYTES),
    .ADDRESS_BITS (ADDRESS_BITS)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .go_i    (load),
    .op_i    (op_r),
    .addr_i  (addr_r),
    .len_i   (len_r),
    .byte_i  (byte_r),
    .burst_o (burst),
    .count_o (count)
  );

  snfcs_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .load_i     (load),
    .burst_i    (burst),
    .count_i    (count),
    .can_load_o (can_load),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .res_o      (res)
  );

  assign out_tx_valid     = res.tx_valid;
  assign out_tx_byte      = res.tx_byte;
  assign out_reply_wanted = res.reply_wanted;
  assign out_release_cs   = res.release_cs;
  assign out_rx_valid     = res.rx_valid;
  assign out_rx_byte      = res.rx_byte;
  assign out_done_res     = res.done_res;
  assign out_error        = res.error;
  assign out_last         = res.last;

endmodule

// ===== tb/tb_spi_nor_flash_command_sequencer.sv =====
// self-checking testbench for the spi nor flash command sequencer: directed and random traffic vs a predictor
`timescale 1ns / 1ps

module tb_spi_nor_flash_command_sequencer;
  import snfcs_pkg::*;

  localparam int          PAGE         = PAGE_BYTES_DEF;
  localparam logic [23:0] ADDR_MASK    = (ADDRESS_BITS_DEF >= 24) ? 24'hFFFFFF :
                                         24'((1 << ADDRESS_BITS_DEF) - 1);
  localparam int          RANDOM_CMDS  = 200;
  localparam int          QUIET_TAIL   = 30;
  localparam int          HOLD_AT      = 60;
  localparam int          HOLD_CYCLES  = 300;
  localparam int          STUCK_LIMIT  = 4000;
  localparam int          DRAIN_CYCLES = 20;

  typedef enum logic [2:0] {
    SEQ_IDLE, SEQ_ID, SEQ_PROG, SEQ_READ, SEQ_POLL_CMD, SEQ_POLL_STAT
  } seq_phase_e;

  typedef enum logic [1:0] {
    POLL_NONE, POLL_ERASE, POLL_PROGRAM
  } poll_owner_e;

  typedef struct packed {
    seq_phase_e  phase;
    logic [23:0] addr;
    logic [23:0] left;
    logic [12:0] page_left;
    poll_owner_e after_poll;
    logic [1:0]  id_left;
  } flash_ctx_t;

  typedef struct packed {
    op_t         op;
    logic [23:0] addr;
    logic [23:0] len;
    logic [7:0]  data;
  } flash_cmd_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_tx_valid;
  logic [7:0]  out_tx_byte;
  logic        out_reply_wanted;
  logic        out_release_cs;
  logic        out_rx_valid;
  logic [7:0]  out_rx_byte;
  logic        out_done_res;
  logic        out_error;
  logic        out_last;
  flash_cmd_t  cur_cmd = '0;

  flash_cmd_t  cmd_queue[$];
  res_t        pending_beats[$];
  flash_ctx_t  model_ctx;
  flash_ctx_t  gen_ctx;
  logic        in_taken = 1'b0;
  int          total_cmds = 0;
  int          cmds_taken = 0;
  int          beats_checked = 0;
  int          refused = 0;
  int          chunk_starts = 0;
  int          fails = 0;
  int          stuck_cycles = 0;
  int          send_gap = 0;
  int          stall_cnt = 0;
  int          hold_cnt = 0;
  bit          hold_done = 1'b0;

  spi_nor_flash_command_sequencer dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_opcode        (cur_cmd.op),
    .in_address       (cur_cmd.addr),
    .in_length        (cur_cmd.len),
    .in_byte_value    (cur_cmd.data),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_tx_valid     (out_tx_valid),
    .out_tx_byte      (out_tx_byte),
    .out_reply_wanted (out_reply_wanted),
    .out_release_cs   (out_release_cs),
    .out_rx_valid     (out_rx_valid),
    .out_rx_byte      (out_rx_byte),
    .out_done_res     (out_done_res),
    .out_error        (out_error),
    .out_last         (out_last)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic void add_beat(inout res_t b[$], input logic txv, input logic [7:0] tx,
                                   input logic rep, input logic rel, input logic rxv,
                                   input logic [7:0] rx, input logic done);
    res_t r;
    r = '0;
    r.tx_valid     = txv;
    r.tx_byte      = txv ? tx : 8'h00;
    r.reply_wanted = rep;
    r.release_cs   = rel;
    r.rx_valid     = rxv;
    r.rx_byte      = rxv ? rx : 8'h00;
    r.done_res     = done;
    b.push_back(r);
  endfunction

  function automatic void add_addr(inout res_t b[$], input logic [23:0] a, input logic rel,
                                   input logic done);
    add_beat(b, 1'b1, a[23:16], 1'b0, 1'b0, 1'b0, 8'h00, 1'b0);
    add_beat(b, 1'b1, a[15:8], 1'b0, 1'b0, 1'b0, 8'h00, 1'b0);
    add_beat(b, 1'b1, a[7:0], 1'b0, rel, 1'b0, 8'h00, done);
  endfunction

  // write enable, page program opcode and address for the next chunk within one page
  function automatic void open_chunk(inout flash_ctx_t c, inout res_t b[$]);
    int space;
    space = PAGE - int'(c.addr % PAGE);
    c.page_left = (int'(c.left) < space) ? 13'(c.left) : 13'(space);
    add_beat(b, 1'b1, CMD_WREN, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0);
    add_beat(b, 1'b1, CMD_PROGRAM, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0);
    add_addr(b, c.addr, 1'b0, 1'b0);
    c.phase = SEQ_PROG;
  endfunction

  function automatic void decode_flash_cmd(inout flash_ctx_t c, input flash_cmd_t cmd,
                                           output res_t burst[$]);
    logic [23:0] a;
    res_t        r;
    a = cmd.addr & ADDR_MASK;
    burst = {};
    if (c.phase == SEQ_IDLE && cmd.op == OP_READ_ID) begin
      add_beat(burst, 1'b1, CMD_JEDEC, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0);
      add_beat(burst, 1'b1, DUMMY_BYTE, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0);
      add_beat(burst, 1'b1, DUMMY_BYTE, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0);
      add_beat(burst, 1'b1, DUMMY_BYTE, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0);
      c.id_left = 2'd3;
      c.phase   = SEQ_ID;
    end else if (c.phase == SEQ_IDLE && cmd.op == OP_POWER_DOWN) begin
      add_beat(burst, 1'b1, CMD_PWRDN, 1'b0, 1'b1, 1'b0, 8'h00, 1'b1);
    end else if (c.phase == SEQ_IDLE && cmd.op == OP_RELEASE) begin
      add_beat(burst, 1'b1, CMD_WAKE, 1'b0, 1'b1, 1'b0, 8'h00, 1'b1);
    end else if (c.phase == SEQ_IDLE && cmd.op == OP_ERASE) begin
      c.addr = a;
      add_beat(burst, 1'b1, CMD_WREN, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0);
      add_beat(burst, 1'b1, CMD_ERASE, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0);
      add_addr(burst, c.addr, 1'b1, 1'b0);
      add_beat(burst, 1'b1, CMD_STATUS, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0);
      c.after_poll = POLL_ERASE;
      c.phase      = SEQ_POLL_CMD;
    end else if (c.phase == SEQ_IDLE && cmd.op == OP_PROG_START) begin
      if (cmd.len == 24'd0) begin
        add_beat(burst, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 8'h00, 1'b1);
      end else begin
        c.addr = a;
        c.left = cmd.len;
        open_chunk(c, burst);
      end
    end else if (c.phase == SEQ_IDLE && cmd.op == OP_READ_START) begin
      c.addr = a;
      add_beat(burst, 1'b1, CMD_READ, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0);
      if (cmd.len == 24'd0) begin
        add_addr(burst, c.addr, 1'b1, 1'b1);
      end else begin
        add_addr(burst, c.addr, 1'b0, 1'b0);
        add_beat(burst, 1'b1, DUMMY_BYTE, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0);
        c.left  = cmd.len;
        c.phase = SEQ_READ;
      end
    end else if (c.phase == SEQ_ID && cmd.op == OP_REPLY) begin
      c.id_left = c.id_left - 2'd1;
      if (c.id_left == 2'd0) begin
        add_beat(burst, 1'b0, 8'h00, 1'b0, 1'b0, 1'b1, cmd.data, 1'b1);
        c.phase = SEQ_IDLE;
      end else begin
        add_beat(burst, 1'b0, 8'h00, 1'b0, 1'b0, 1'b1, cmd.data, 1'b0);
      end
    end else if (c.phase == SEQ_READ && cmd.op == OP_REPLY) begin
      c.left = c.left - 24'd1;
      c.addr = (c.addr + 24'd1) & ADDR_MASK;
      if (c.left == 24'd0) begin
        add_beat(burst, 1'b0, 8'h00, 1'b0, 1'b1, 1'b1, cmd.data, 1'b1);
        c.phase = SEQ_IDLE;
      end else begin
        add_beat(burst, 1'b0, 8'h00, 1'b0, 1'b0, 1'b1, cmd.data, 1'b0);
        add_beat(burst, 1'b1, DUMMY_BYTE, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0);
      end
    end else if (c.phase == SEQ_PROG && cmd.op == OP_PROG_BYTE) begin
      c.addr      = (c.addr + 24'd1) & ADDR_MASK;
      c.left      = c.left - 24'd1;
      c.page_left = c.page_left - 13'd1;
      if (c.page_left == 13'd0) begin
        add_beat(burst, 1'b1, cmd.data, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0);
        add_beat(burst, 1'b1, CMD_STATUS, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0);
        c.after_poll = POLL_PROGRAM;
        c.phase      = SEQ_POLL_CMD;
      end else begin
        add_beat(burst, 1'b1, cmd.data, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0);
      end
    end else if (c.phase == SEQ_POLL_CMD && cmd.op == OP_REPLY) begin
      // answer to the status opcode itself is a dummy
      add_beat(burst, 1'b1, DUMMY_BYTE, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0);
      c.phase = SEQ_POLL_STAT;
    end else if (c.phase == SEQ_POLL_STAT && cmd.op == OP_REPLY) begin
      if (cmd.data[0]) begin
        add_beat(burst, 1'b1, DUMMY_BYTE, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0);
      end else if (c.after_poll == POLL_PROGRAM && c.left != 24'd0) begin
        add_beat(burst, 1'b0, 8'h00, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0);
        open_chunk(c, burst);
      end else begin
        add_beat(burst, 1'b0, 8'h00, 1'b0, 1'b1, 1'b0, 8'h00, 1'b1);
        c.after_poll = POLL_NONE;
        c.phase      = SEQ_IDLE;
      end
    end else begin
      r = '0;
      r.error = 1'b1;
      burst.push_back(r);
    end
    burst[burst.size()-1].last = 1'b1;
  endfunction

  task automatic queue_cmd(input op_t op, input logic [23:0] a, input logic [23:0] l,
                           input logic [7:0] d);
    flash_cmd_t cmd;
    res_t       scratch[$];
    cmd.op   = op;
    cmd.addr = a;
    cmd.len  = l;
    cmd.data = d;
    decode_flash_cmd(gen_ctx, cmd, scratch);
    cmd_queue.push_back(cmd);
  endtask

  // mostly well-formed traffic for the current phase, with some out-of-phase noise
  task automatic gen_random_cmd();
    logic [23:0] a;
    logic [23:0] l;
    logic [7:0]  d;
    int          pick;
    int          r;
    op_t         op;
    a    = 24'($urandom);
    l    = 24'($urandom);
    d    = 8'($urandom);
    pick = $urandom_range(0, 99);
    r    = $urandom_range(0, 9);
    if (gen_ctx.phase == SEQ_IDLE) begin
      if (pick < 12) begin
        queue_cmd((pick < 6) ? OP_PROG_BYTE : OP_REPLY, a, l, d);
      end else begin
        case ($urandom_range(0, 6))
          0: op = OP_READ_ID;
          1: op = OP_POWER_DOWN;
          2: op = OP_RELEASE;
          3: op = OP_ERASE;
          4, 5: op = OP_PROG_START;
          default: op = OP_READ_START;
        endcase
        if (op == OP_PROG_START) begin
          if (r < 2) begin
            l = 24'd0;
          end else if (r < 8) begin
            l = 24'($urandom_range(1, 6));
          end else begin
            // start near the page end so the program can split
            l = 24'($urandom_range(7, 24));
            a[7:0] = 8'($urandom_range(232, 255));
          end
        end else if (op == OP_READ_START) begin
          l = (r < 2) ? 24'd0 : 24'($urandom_range(1, 6));
        end
        queue_cmd(op, a, l, d);
      end
    end else if (pick < 10) begin
      queue_cmd(op_t'($urandom_range(0, 7)), a, l, d);
    end else if (gen_ctx.phase == SEQ_PROG) begin
      queue_cmd(OP_PROG_BYTE, a, l, d);
    end else begin
      if (gen_ctx.phase == SEQ_POLL_STAT) begin
        d[0] = ($urandom_range(0, 2) == 0);
      end
      queue_cmd(OP_REPLY, a, l, d);
    end
  endtask

  task automatic cmp_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      fails++;
    end
  endtask

  // sender: one transaction held until taken, random gaps between transactions
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_taken)) begin
      if (send_gap > 0) begin
        send_gap = send_gap - 1;
        in_valid <= 1'b0;
      end else if (cmd_queue.size() == 0) begin
        in_valid <= 1'b0;
      end else if (cmd_queue.size() >= QUIET_TAIL && $urandom_range(0, 5) == 0) begin
        send_gap = $urandom_range(1, 16) - 1;
        in_valid <= 1'b0;
      end else begin
        cur_cmd  <= cmd_queue.pop_front();
        in_valid <= 1'b1;
      end
    end
  end

  // receiver: random stalls plus one long hold-off so the input side backs up
  always @(negedge clk) begin
    if (rst_n) begin
      if (hold_cnt > 0) begin
        hold_cnt = hold_cnt - 1;
        out_ready <= 1'b0;
      end else if (!hold_done && cmds_taken >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_cnt  = HOLD_CYCLES - 1;
        out_ready <= 1'b0;
      end else if (stall_cnt > 0) begin
        stall_cnt = stall_cnt - 1;
        out_ready <= 1'b0;
      end else if (cmd_queue.size() >= QUIET_TAIL && $urandom_range(0, 5) == 0) begin
        stall_cnt = $urandom_range(1, 16) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : monitor
    res_t want;
    res_t burst[$];
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && in_ready;
      if (in_valid && in_ready) begin
        decode_flash_cmd(model_ctx, cur_cmd, burst);
        foreach (burst[i]) pending_beats.push_back(burst[i]);
        if (cur_cmd.op == OP_PROG_BYTE || cur_cmd.op == OP_REPLY) begin
          if (model_ctx.phase == SEQ_PROG && burst.size() > 1) chunk_starts++;
        end
        cmds_taken++;
      end
      if (out_valid && out_ready) begin
        beats_checked++;
        if (pending_beats.size() == 0) begin
          $error("result transaction with nothing pending");
          fails++;
        end else begin
          want = pending_beats.pop_front();
          cmp_field("tx_valid", 8'(want.tx_valid), 8'(out_tx_valid));
          cmp_field("tx_byte", want.tx_byte, out_tx_byte);
          cmp_field("reply_wanted", 8'(want.reply_wanted), 8'(out_reply_wanted));
          cmp_field("release_cs", 8'(want.release_cs), 8'(out_release_cs));
          cmp_field("rx_valid", 8'(want.rx_valid), 8'(out_rx_valid));
          cmp_field("rx_byte", want.rx_byte, out_rx_byte);
          cmp_field("done_res", 8'(want.done_res), 8'(out_done_res));
          cmp_field("error", 8'(want.error), 8'(out_error));
          cmp_field("last", 8'(want.last), 8'(out_last));
          if (want.error) refused++;
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        stuck_cycles <= 0;
      end else begin
        stuck_cycles <= stuck_cycles + 1;
      end
    end
  end

  initial begin
    while (stuck_cycles < STUCK_LIMIT) @(posedge clk);
    $display("timeout: no transaction for %0d cycles", STUCK_LIMIT);
    $display("FAIL spi_nor_flash_command_sequencer");
    $finish;
  end

  initial begin
    model_ctx = '0;
    gen_ctx   = '0;

    // out-of-phase items while idle
    queue_cmd(OP_REPLY, 24'h000000, 24'h000000, 8'h5A);
    queue_cmd(OP_PROG_BYTE, 24'hFFFFFF, 24'hFFFFFF, 8'hFF);
    // jedec id with three reply bytes
    queue_cmd(OP_READ_ID, 24'h000000, 24'h000000, 8'h00);
    queue_cmd(OP_REPLY, 24'h000000, 24'h000000, 8'h00);
    queue_cmd(OP_REPLY, 24'hFFFFFF, 24'hFFFFFF, 8'hFF);
    queue_cmd(OP_REPLY, 24'h555555, 24'hAAAAAA, 8'hC2);
    queue_cmd(OP_POWER_DOWN, 24'hAAAAAA, 24'h555555, 8'h55);
    queue_cmd(OP_RELEASE, 24'h555555, 24'hAAAAAA, 8'hAA);
    // erase at the top address, a new command while busy, then a busy poll
    queue_cmd(OP_ERASE, 24'hFFFFFF, 24'h000000, 8'h00);
    queue_cmd(OP_READ_START, 24'h123456, 24'hFFFFFF, 8'h00);
    queue_cmd(OP_REPLY, 24'h000000, 24'h000000, 8'h00);
    queue_cmd(OP_REPLY, 24'h000000, 24'h000000, 8'hFF);
    queue_cmd(OP_REPLY, 24'h000000, 24'h000000, 8'h01);
    queue_cmd(OP_REPLY, 24'h000000, 24'h000000, 8'hFE);
    // zero-length program and read
    queue_cmd(OP_PROG_START, 24'h123456, 24'h000000, 8'h00);
    queue_cmd(OP_READ_START, 24'hABCDEF, 24'h000000, 8'h00);
    // read across the address wrap
    queue_cmd(OP_READ_START, 24'hFFFFFF, 24'h000002, 8'h00);
    queue_cmd(OP_REPLY, 24'h000000, 24'h000000, 8'h3C);
    queue_cmd(OP_REPLY, 24'h000000, 24'h000000, 8'hC3);
    // program split at the page end and at the address wrap
    queue_cmd(OP_PROG_START, 24'hFFFFFE, 24'h000003, 8'h00);
    queue_cmd(OP_PROG_BYTE, 24'h000000, 24'h000000, 8'h00);
    queue_cmd(OP_PROG_BYTE, 24'h000000, 24'h000000, 8'hFF);
    queue_cmd(OP_REPLY, 24'h000000, 24'h000000, 8'h00);
    queue_cmd(OP_REPLY, 24'h000000, 24'h000000, 8'h00);
    queue_cmd(OP_PROG_BYTE, 24'h000000, 24'h000000, 8'hA5);
    queue_cmd(OP_REPLY, 24'h000000, 24'h000000, 8'h00);
    queue_cmd(OP_REPLY, 24'h000000, 24'h000000, 8'h00);

    total_cmds = cmd_queue.size() + RANDOM_CMDS;
    while (cmd_queue.size() < total_cmds || gen_ctx.phase != SEQ_IDLE) gen_random_cmd();
    total_cmds = cmd_queue.size();

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (cmds_taken < total_cmds) @(posedge clk);
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d commands, %0d result transactions checked, %0d refused out of phase",
             cmds_taken, beats_checked, refused);
    $display("program chunks continued after a busy poll: %0d", chunk_starts);
    if (fails == 0) begin
      $display("PASS spi_nor_flash_command_sequencer");
    end else begin
      $display("FAIL spi_nor_flash_command_sequencer");
    end
    $finish;
  end

endmodule
